// File: src/fsc_pkg.sv
// Package for the frustum sphere cull unit: plane count, fixed-point widths,
// request and status types and the containment codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fsc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT   = 6;
	localparam int CFG_IDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int PLANE_W     = 64;
	localparam int COORD_W     = 16;
	localparam int RADIUS_W    = 15;
	localparam int PROD_W      = 32;
	localparam int DIST_W      = 36;
	localparam int FRAC_SHIFT  = 14;
	localparam int LATENCY     = 2 * PLANE_COUNT;

	typedef logic [PLANE_W-1:0] plane_t;

	typedef enum logic [1:0] {
		CONTAIN_INSIDE    = 2'd0,
		CONTAIN_INTERSECT = 2'd1,
		CONTAIN_OUTSIDE   = 2'd2
	} contain_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [RADIUS_W-1:0]       r;
	} sphere_t;

	typedef struct packed {
		logic outside;
		logic overlap;
	} cull_sts_t;

endpackage
`default_nettype wire

// File: src/frustum_sphere_cull_unit.sv
// Top level of the frustum sphere cull unit: plane registers, chain of plane
// cells and result decode. Depends on fsc_pkg and fsc_cell.
//
//   channel   handshake               payload
//   request   start, busy             center_x, center_y, center_z, radius
//   result    done (one-cycle strobe) containment
//   config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One request per cycle; busy stays low. Each cell registers the multiply for its
// plane, then the sum and compare, and the cells run in plane order. Reset
// clears the plane registers to zero and empties the chain. The result side
// cannot stall; config is always ready.
`timescale 1ns / 1ps
`default_nettype none
module frustum_sphere_cull_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [15:0]        center_x,
	input  wire logic signed [15:0]        center_y,
	input  wire logic signed [15:0]        center_z,
	input  wire logic [14:0]               radius,
	output logic                           done,
	output fsc_pkg::contain_t              containment,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fsc_pkg::PLANE_W-1:0]   cfg_data
);
	import fsc_pkg::*;

	plane_t    plane_q [REG_COUNT];
	logic      chain_valid [PLANE_COUNT+1];
	sphere_t   chain_item  [PLANE_COUNT+1];
	cull_sts_t chain_sts   [PLANE_COUNT+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < REG_COUNT; i++) begin
				if (cfg_valid && cfg_ready && cfg_index == CFG_IDX_W'(i)) begin
					plane_q[i] <= cfg_data;
				end
			end
		end
	end

	assign chain_valid[0]     = start & ~busy;
	assign chain_item[0].x    = center_x;
	assign chain_item[0].y    = center_y;
	assign chain_item[0].z    = center_z;
	assign chain_item[0].r    = radius;
	assign chain_sts[0]       = '{outside: 1'b0, overlap: 1'b0};

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
		plane_t plane;
		if (g < REG_COUNT) begin : g_reg
			assign plane = plane_q[g];
		end else begin : g_zero
			assign plane = '0;
		end
		fsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (plane),
			.in_valid  (chain_valid[g]),
			.in_item   (chain_item[g]),
			.in_sts    (chain_sts[g]),
			.out_valid (chain_valid[g+1]),
			.out_item  (chain_item[g+1]),
			.out_sts   (chain_sts[g+1])
		);
	end

	assign done = chain_valid[PLANE_COUNT];

	always_comb begin
		priority if (chain_sts[PLANE_COUNT].outside) begin
			containment = CONTAIN_OUTSIDE;
		end else if (chain_sts[PLANE_COUNT].overlap) begin
			containment = CONTAIN_INTERSECT;
		end else begin
			containment = CONTAIN_INSIDE;
		end
	end

endmodule
`default_nettype wire

// File: src/fsc_cell.sv
// One plane cell of the cull chain: multiply stage, then sum and compare stage.
// Depends on fsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsc_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fsc_pkg::plane_t   plane,
	input  wire logic              in_valid,
	input  wire fsc_pkg::sphere_t  in_item,
	input  wire fsc_pkg::cull_sts_t in_sts,
	output logic                   out_valid,
	output fsc_pkg::sphere_t       out_item,
	output fsc_pkg::cull_sts_t     out_sts
);
	import fsc_pkg::*;

	logic signed [COORD_W-1:0] a, b, c;
	logic signed [PROD_W-1:0]  ax_s1, by_s1, cz_s1;
	logic signed [COORD_W-1:0] d_s1;
	logic                      valid_s1;
	sphere_t                   item_s1;
	cull_sts_t                 sts_s1;
	logic signed [DIST_W-1:0]  distance;
	logic signed [DIST_W-1:0]  r_pos;
	logic signed [DIST_W-1:0]  r_neg;
	logic signed [DIST_W-1:0]  d_scaled;
	logic                      valid_s2;
	sphere_t                   item_s2;
	cull_sts_t                 sts_s2;

	assign a = plane[63:48];
	assign b = plane[47:32];
	assign c = plane[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1   <= a * in_item.x;
		by_s1   <= b * in_item.y;
		cz_s1   <= c * in_item.z;
		d_s1    <= plane[15:0];
		item_s1 <= in_item;
		sts_s1  <= in_sts;
	end

	assign d_scaled = {{(DIST_W-COORD_W-FRAC_SHIFT){d_s1[COORD_W-1]}}, d_s1,
		{FRAC_SHIFT{1'b0}}};
	assign r_pos    = {{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, item_s1.r,
		{FRAC_SHIFT{1'b0}}};
	assign r_neg    = -r_pos;
	assign distance = DIST_W'(ax_s1) + DIST_W'(by_s1) + DIST_W'(cz_s1) + d_scaled;

	always_ff @(posedge clk) begin
		item_s2         <= item_s1;
		sts_s2.outside  <= sts_s1.outside | (distance < r_neg);
		sts_s2.overlap  <= sts_s1.overlap | (distance < r_pos);
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;
	assign out_sts   = sts_s2;

endmodule
`default_nettype wire

// File: src/fsc_checker.sv
// Port-level checker for the frustum sphere cull unit, bound to the top level.
// Depends on fsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [1:0] containment,
	input wire logic       cfg_ready
);
	import fsc_pkg::*;

	localparam int WARM_W = $clog2(LATENCY + 1);

	logic [WARM_W-1:0] warm_q;
	logic              warm;

	assign warm = (warm_q == WARM_W'(LATENCY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (!warm) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("request or config stalled");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (containment != 2'd3))
		else $error("illegal containment code");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LATENCY)))
		else $error("result strobe does not match request latency");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!warm |-> !done)
		else $error("result strobe before any request could finish");

endmodule

bind frustum_sphere_cull_unit fsc_checker u_fsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.containment (containment),
	.cfg_ready   (cfg_ready)
);
`default_nettype wire
